// ===== rtl/kwq_pkg.sv =====
// Shared constants, codes and types of the keyed wait queue block.
`timescale 1ns / 1ps
package kwq_pkg;

  localparam int KEY_SLOTS       = 16;
  localparam int WAITERS_PER_KEY = 16;
  localparam int CLIENT_COUNT    = 256;

  localparam int OP_W        = 2;
  localparam int KEY_IDX_W   = 4;
  localparam int CLIENT_ID_W = 8;

  localparam int KEY_W  = $clog2(KEY_SLOTS);
  localparam int SLOT_W = $clog2(WAITERS_PER_KEY);
  localparam int CNT_W  = $clog2(WAITERS_PER_KEY + 1);
  localparam int RCNT_W = $clog2(KEY_SLOTS + 1);
  localparam int CID_W  = $clog2(CLIENT_COUNT);
  localparam int TOT_W  = $clog2(KEY_SLOTS * WAITERS_PER_KEY + 1);
  localparam int RAM_DEPTH = KEY_SLOTS * WAITERS_PER_KEY;
  localparam int RAM_AW = $clog2(RAM_DEPTH);

  localparam logic [OP_W-1:0] OP_BLOCK  = 2'd0;
  localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

  typedef enum logic [1:0] {
    K_BLOCK,
    K_SIGNAL,
    K_DRAIN,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              key_ok;
    logic              cid_ok;
    logic [KEY_W-1:0]  key;
    logic [CID_W-1:0]  cid;
    logic              is_list;
  } cmd_t;

  typedef struct packed {
    logic                   accepted;
    logic                   queue_full;
    logic                   woken_valid;
    logic [CLIENT_ID_W-1:0] woken_client;
    logic [KEY_IDX_W-1:0]   drained_key;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [CID_W-1:0]  wdata;
    logic              re;
    logic [RAM_AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/kwq_if.sv =====
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
interface kwq_in_if import kwq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [KEY_IDX_W-1:0]   key_index;
  logic [CLIENT_ID_W-1:0] client_id;
  logic                   value_is_list;
  modport source (output valid, op, key_index, client_id, value_is_list, input ready);
  modport sink (input valid, op, key_index, client_id, value_is_list, output ready);
endinterface

interface kwq_out_if import kwq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic                   queue_full;
  logic                   woken_valid;
  logic [CLIENT_ID_W-1:0] woken_client;
  logic [KEY_IDX_W-1:0]   drained_key;
  logic                   last;
  modport source (output valid, accepted, queue_full, woken_valid, woken_client,
                  drained_key, last, input ready);
  modport sink (input valid, accepted, queue_full, woken_valid, woken_client,
                drained_key, last, output ready);
endinterface

// ===== rtl/kwq_ram.sv =====
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module kwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/kwq_front.sv =====
// Front end: accepts requests, classifies them and buffers them in a short queue.
`timescale 1ns / 1ps
module kwq_front import kwq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  kwq_in_if.sink   items,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);
  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded         = '0;
    decoded.key_ok  = 32'(items.key_index) < KEY_SLOTS;
    decoded.cid_ok  = 32'(items.client_id) < CLIENT_COUNT;
    decoded.key     = KEY_W'(items.key_index);
    decoded.cid     = CID_W'(items.client_id);
    decoded.is_list = items.value_is_list;
    unique case (items.op)
      OP_BLOCK:  decoded.kind = K_BLOCK;
      OP_SIGNAL: decoded.kind = K_SIGNAL;
      OP_DRAIN:  decoded.kind = K_DRAIN;
      default:   decoded.kind = K_NOP;
    endcase
  end

  assign items.ready = (cnt != 2'd2);
  assign cmd_valid   = (cnt != 2'd0);
  assign cmd         = q[rptr];
  assign push        = items.valid && items.ready;
  assign pop         = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        q[wptr] <= decoded;
        wptr    <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/kwq_back.sv =====
// Back end: carries out block, signal and drain requests on the queue state.
`timescale 1ns / 1ps
module kwq_back import kwq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  cmd_t     cmd,
  output ram_req_t ram_req,
  input  logic [CID_W-1:0] ram_rdata,
  output logic     res_valid,
  input  logic     res_ready,
  output res_t     res
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAKE
  } state_t;

  state_t                  state;
  logic [SLOT_W-1:0]       waiter_head  [KEY_SLOTS];
  logic [CNT_W-1:0]        waiter_count [KEY_SLOTS];
  logic [KEY_SLOTS-1:0]    key_seen;
  logic [KEY_W-1:0]        ready_fifo   [KEY_SLOTS];
  logic [KEY_W-1:0]        ready_head;
  logic [RCNT_W-1:0]       ready_count;
  logic [KEY_SLOTS-1:0]    ready_mark;
  logic [CLIENT_COUNT-1:0] client_blocked;
  logic [TOT_W-1:0]        blocked_total;
  logic [KEY_W-1:0]        cur_key;
  logic                    cur_last;

  logic              out_free;
  logic              take;
  logic              blk_full;
  logic              blk_ok;
  logic              sig_ok;
  logic [CNT_W:0]    slot_sum;
  logic [SLOT_W-1:0] slot;
  logic [RCNT_W:0]   tail_sum;
  logic [KEY_W-1:0]  tail;
  logic [KEY_W-1:0]  pop_key;
  logic [KEY_W-1:0]  head_inc;
  logic              wake_ok;
  logic [SLOT_W-1:0] wh_inc;
  logic              res_load;
  res_t              res_idle;
  res_t              res_wake;

  always_comb begin
    out_free  = !res_valid || res_ready;
    cmd_ready = (state == S_IDLE) && out_free;
    take      = cmd_valid && cmd_ready;
    blk_full  = waiter_count[cmd.key] >= CNT_W'(WAITERS_PER_KEY);
    blk_ok    = cmd.key_ok && cmd.cid_ok && !blk_full;
    sig_ok    = cmd.key_ok && cmd.is_list && (blocked_total != '0) && key_seen[cmd.key] &&
                !ready_mark[cmd.key] && (ready_count < RCNT_W'(KEY_SLOTS));
    slot_sum  = (CNT_W+1)'(waiter_head[cmd.key]) + (CNT_W+1)'(waiter_count[cmd.key]);
    slot      = (slot_sum >= (CNT_W+1)'(WAITERS_PER_KEY)) ?
                SLOT_W'(slot_sum - (CNT_W+1)'(WAITERS_PER_KEY)) : SLOT_W'(slot_sum);
    tail_sum  = (RCNT_W+1)'(ready_head) + (RCNT_W+1)'(ready_count);
    tail      = (tail_sum >= (RCNT_W+1)'(KEY_SLOTS)) ?
                KEY_W'(tail_sum - (RCNT_W+1)'(KEY_SLOTS)) : KEY_W'(tail_sum);
    pop_key   = ready_fifo[ready_head];
    head_inc  = (32'(ready_head) == KEY_SLOTS - 1) ? '0 : ready_head + 1'b1;
    wake_ok   = (waiter_count[cur_key] != '0) && client_blocked[ram_rdata];
    wh_inc    = (32'(waiter_head[cur_key]) == WAITERS_PER_KEY - 1) ?
                '0 : waiter_head[cur_key] + 1'b1;

    res_load  = (take && !((cmd.kind == K_DRAIN) && (ready_count != '0))) ||
                ((state == S_WAKE) && out_free);

    res_idle      = '0;
    res_idle.last = 1'b1;
    if (cmd.kind == K_BLOCK) begin
      res_idle.accepted   = blk_ok;
      res_idle.queue_full = cmd.key_ok && cmd.cid_ok && blk_full;
    end else if (cmd.kind == K_SIGNAL) begin
      res_idle.accepted = sig_ok;
    end

    res_wake              = '0;
    res_wake.drained_key  = KEY_IDX_W'(cur_key);
    res_wake.last         = cur_last;
    res_wake.woken_valid  = wake_ok;
    res_wake.woken_client = wake_ok ? CLIENT_ID_W'(ram_rdata) : '0;

    ram_req.we    = take && (cmd.kind == K_BLOCK) && blk_ok;
    ram_req.waddr = RAM_AW'(cmd.key) * RAM_AW'(WAITERS_PER_KEY) + RAM_AW'(slot);
    ram_req.wdata = cmd.cid;
    ram_req.re    = (state == S_READ);
    ram_req.raddr = RAM_AW'(pop_key) * RAM_AW'(WAITERS_PER_KEY) +
                    RAM_AW'(waiter_head[pop_key]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      key_seen       <= '0;
      ready_mark     <= '0;
      client_blocked <= '0;
      ready_head     <= '0;
      ready_count    <= '0;
      blocked_total  <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        waiter_head[i]  <= '0;
        waiter_count[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
        res       <= (state == S_WAKE) ? res_wake : res_idle;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.kind)
              K_BLOCK: begin
                if (blk_ok) begin
                  waiter_count[cmd.key]   <= waiter_count[cmd.key] + 1'b1;
                  key_seen[cmd.key]       <= 1'b1;
                  client_blocked[cmd.cid] <= 1'b1;
                  blocked_total           <= blocked_total + 1'b1;
                end
              end
              K_SIGNAL: begin
                if (sig_ok) begin
                  ready_fifo[tail]    <= cmd.key;
                  ready_count         <= ready_count + 1'b1;
                  ready_mark[cmd.key] <= 1'b1;
                end
              end
              K_DRAIN: begin
                if (ready_count != '0) begin
                  state <= S_READ;
                end
              end
              K_NOP: begin
              end
            endcase
          end
        end
        S_READ: begin
          cur_key             <= pop_key;
          cur_last            <= (ready_count == RCNT_W'(1));
          ready_head          <= head_inc;
          ready_count         <= ready_count - 1'b1;
          ready_mark[pop_key] <= 1'b0;
          state               <= S_WAKE;
        end
        S_WAKE: begin
          if (out_free) begin
            if (wake_ok) begin
              client_blocked[ram_rdata] <= 1'b0;
              if (blocked_total != '0) begin
                blocked_total <= blocked_total - 1'b1;
              end
              waiter_head[cur_key]  <= wh_inc;
              waiter_count[cur_key] <= waiter_count[cur_key] - 1'b1;
            end
            state <= cur_last ? S_IDLE : S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ready_count) <= KEY_SLOTS)
    else $error("ready queue count exceeds the number of keys");

  a_mark_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(ready_mark) == 32'(ready_count))
    else $error("ready marks disagree with the ready queue count");

  a_total_covers_blocked: assert property (@(posedge clk) disable iff (rst)
    32'(blocked_total) >= $countones(client_blocked))
    else $error("blocked total is below the number of blocked clients");

  a_wake_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAKE) && out_free |=> res_valid)
    else $error("a drained key produced no result");
endmodule

// ===== rtl/keyed_wait_queue_wakeup.sv =====
// Top level of the keyed wait queue block with its deduplicated ready queue.
//
// Requests arrive on the items channel and results leave on the results
// channel; a transfer happens when valid and ready are both high.
// Block and signal requests give one result each, with last set.
// A drain gives one result per key popped from the ready queue, last on
// the final one, or a single empty result when no key is ready.
// The front end buffers up to two requests, so requests can still be taken
// while the back end works or a result waits, until both entries are full.
// Block, signal and unused requests load their result into the output register
// when the back end takes them; a drain steps through a read state, for the
// registered read of the waiter store, and a wake state for each popped key.
// One request is carried out at a time by the back end.
// Reset clears all queue counters, marks and blocked flags;
// the waiter store holds no reset value and needs no clearing pass.
// When the receiver stalls, the result is held and the back end waits.
`timescale 1ns / 1ps
module keyed_wait_queue_wakeup import kwq_pkg::*; (
  input logic       clk,
  input logic       rst,
  kwq_in_if.sink    items,
  kwq_out_if.source results
);
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;
  ram_req_t          ram_req;
  logic [CID_W-1:0]  ram_rdata;
  res_t              res;

  kwq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  kwq_ram #(
    .WIDTH (CID_W),
    .DEPTH (RAM_DEPTH)
  ) u_waiter_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  kwq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (res)
  );

  assign results.accepted     = res.accepted;
  assign results.queue_full   = res.queue_full;
  assign results.woken_valid  = res.woken_valid;
  assign results.woken_client = res.woken_client;
  assign results.drained_key  = res.drained_key;
  assign results.last         = res.last;
endmodule

// ===== verif/keyed_wait_queue_wakeup_test.sv =====
// Self-checking testbench for the keyed wait queue block: directed table, then random traffic.
`timescale 1ns / 1ps
module keyed_wait_queue_wakeup_test;
  import kwq_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [KEY_IDX_W-1:0]   key_index;
    logic [CLIENT_ID_W-1:0] client_id;
    logic                   value_is_list;
  } req_t;

  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kwq_in_if  items();
  kwq_out_if results();

  keyed_wait_queue_wakeup dut (
    .clk(clk),
    .rst(rst),
    .items(items.sink),
    .results(results.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [CID_W-1:0] wq_store [KEY_SLOTS][WAITERS_PER_KEY];
  int unsigned wq_head [KEY_SLOTS];
  int unsigned wq_count [KEY_SLOTS];
  bit          wq_seen [KEY_SLOTS];
  int unsigned rdy_ring [KEY_SLOTS];
  int unsigned rdy_head;
  int unsigned rdy_count;
  bit          rdy_mark [KEY_SLOTS];
  bit          cl_blocked [CLIENT_COUNT];
  int unsigned blocked_sum;

  res_t wakeup_q[$];
  int   errors;
  int   sent;
  int   got;
  int   woke;
  bit   sending;

  task automatic report(input string what, input res_t g, input res_t e);
    errors++;
    $display("mismatch %s: got %h expected %h", what, g, e);
  endtask

  function automatic res_t mk(input bit acc, input bit full, input bit wv,
                              input int wc, input int dk, input bit lst);
    res_t r;
    r.accepted = acc;
    r.queue_full = full;
    r.woken_valid = wv;
    r.woken_client = CLIENT_ID_W'(wc);
    r.drained_key = KEY_IDX_W'(dk);
    r.last = lst;
    return r;
  endfunction

  task automatic predict_wakeups(input req_t r);
    int k;
    int c;
    int h;
    bit ok;
    k = int'(r.key_index);
    case (r.op)
      OP_BLOCK: begin
        if (wq_count[k] >= WAITERS_PER_KEY) begin
          wakeup_q.push_back(mk(0, 1, 0, 0, 0, 1));
        end else begin
          wq_store[k][(wq_head[k] + wq_count[k]) % WAITERS_PER_KEY] = r.client_id;
          wq_count[k]++;
          wq_seen[k] = 1;
          cl_blocked[r.client_id] = 1;
          blocked_sum++;
          wakeup_q.push_back(mk(1, 0, 0, 0, 0, 1));
        end
      end
      OP_SIGNAL: begin
        ok = r.value_is_list && blocked_sum != 0 && wq_seen[k] && !rdy_mark[k]
             && rdy_count < KEY_SLOTS;
        if (ok) begin
          rdy_ring[(rdy_head + rdy_count) % KEY_SLOTS] = k;
          rdy_count++;
          rdy_mark[k] = 1;
        end
        wakeup_q.push_back(mk(ok, 0, 0, 0, 0, 1));
      end
      OP_DRAIN: begin
        if (rdy_count == 0) wakeup_q.push_back(mk(0, 0, 0, 0, 0, 1));
        while (rdy_count > 0) begin
          k = rdy_ring[rdy_head];
          rdy_head = (rdy_head + 1) % KEY_SLOTS;
          rdy_count--;
          rdy_mark[k] = 0;
          ok = 0;
          c = 0;
          if (wq_count[k] > 0) begin
            h = wq_head[k];
            if (cl_blocked[wq_store[k][h]]) begin
              c = int'(wq_store[k][h]);
              cl_blocked[c] = 0;
              if (blocked_sum > 0) blocked_sum--;
              wq_head[k] = (h + 1) % WAITERS_PER_KEY;
              wq_count[k]--;
              ok = 1;
            end
          end
          wakeup_q.push_back(mk(0, 0, ok, c, k, rdy_count == 0));
        end
      end
      default: wakeup_q.push_back(mk(0, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic send(input req_t r);
    int gap;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items.valid <= 1'b1;
    items.op <= r.op;
    items.key_index <= r.key_index;
    items.client_id <= r.client_id;
    items.value_is_list <= r.value_is_list;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    predict_wakeups(r);
    sent++;
    @(negedge clk);
  endtask

  function automatic req_t rq(input int op, input int k, input int c, input bit l);
    req_t r;
    r.op = OP_W'(op);
    r.key_index = KEY_IDX_W'(k);
    r.client_id = CLIENT_ID_W'(c);
    r.value_is_list = l;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t g;
    res_t e;
    if (!rst && results.valid && results.ready) begin
      g.accepted = results.accepted;
      g.queue_full = results.queue_full;
      g.woken_valid = results.woken_valid;
      g.woken_client = results.woken_client;
      g.drained_key = results.drained_key;
      g.last = results.last;
      got++;
      if (g.woken_valid) woke++;
      if (wakeup_q.size() == 0) begin
        report("unexpected result", g, g);
      end else begin
        e = wakeup_q.pop_front();
        if (g !== e) report("field", g, e);
      end
    end
  end

  initial begin
    int hold;
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
        if (results.valid && $urandom_range(0, 3) == 0) hold = $urandom_range(0, 15);
        if (!sending) hold = 0;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t w;
    int k;
    int burst;
    items.valid = 1'b0;
    items.op = '0;
    items.key_index = '0;
    items.client_id = '0;
    items.value_is_list = 1'b0;
    sending = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    w.fixed = 1;
    w.req = rq(OP_DRAIN, 0, 0, 0);  w.res = mk(0, 0, 0, 0, 0, 1); rows.push_back(w);
    w.req = rq(OP_SIGNAL, 15, 0, 1); w.res = mk(0, 0, 0, 0, 0, 1); rows.push_back(w);
    w.req = rq(3, 15, 255, 1);      w.res = mk(0, 0, 0, 0, 0, 1); rows.push_back(w);
    w.req = rq(OP_BLOCK, 15, 255, 0); w.res = mk(1, 0, 0, 0, 0, 1); rows.push_back(w);
    w.req = rq(OP_BLOCK, 0, 0, 1);  w.res = mk(1, 0, 0, 0, 0, 1); rows.push_back(w);
    w.fixed = 0;
    rows.push_back('{rq(OP_SIGNAL, 15, 0, 0), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 15, 0, 1), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 15, 0, 1), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 0, 0, 1), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 7, 0, 1), 0, '0});
    rows.push_back('{rq(OP_DRAIN, 0, 0, 0), 0, '0});
    rows.push_back('{rq(OP_BLOCK, 5, 9, 0), 0, '0});
    rows.push_back('{rq(OP_BLOCK, 6, 9, 0), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 5, 0, 1), 0, '0});
    rows.push_back('{rq(OP_SIGNAL, 6, 0, 1), 0, '0});
    rows.push_back('{rq(OP_DRAIN, 0, 0, 0), 0, '0});
    for (int i = 0; i < WAITERS_PER_KEY; i++)
      rows.push_back('{rq(OP_BLOCK, 3, 100 + i, 0), 0, '0});
    w.fixed = 1;
    w.req = rq(OP_BLOCK, 3, 170, 1); w.res = mk(0, 1, 0, 0, 0, 1); rows.push_back(w);

    foreach (rows[i]) begin
      send(rows[i].req);
      if (rows[i].fixed && wakeup_q[wakeup_q.size() - 1] !== rows[i].res)
        report("table row", wakeup_q[wakeup_q.size() - 1], rows[i].res);
    end

    while (sent < 320) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++)
        send(rq(OP_BLOCK, $urandom_range(0, 15), $urandom_range(0, 255),
                $urandom_range(0, 1)));
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst; i++)
        send(rq(OP_SIGNAL, $urandom_range(0, 15), $urandom_range(0, 255),
                $urandom_range(0, 5) != 0));
      k = $urandom_range(0, 9);
      if (k == 0) send(rq(3, $urandom_range(0, 15), $urandom_range(0, 255),
                          $urandom_range(0, 1)));
      send(rq(OP_DRAIN, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1)));
    end
    items.valid <= 1'b0;

    sending = 1'b0;
    while (wakeup_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d requests and %0d results, %0d of them wakeups.", sent, got, woke);
    if (errors == 0) begin
      $display("keyed_wait_queue_wakeup_test: PASS");
    end else begin
      $display("keyed_wait_queue_wakeup_test: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("keyed_wait_queue_wakeup_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kwq_pkg.sv
rtl/kwq_if.sv
rtl/kwq_ram.sv
rtl/kwq_front.sv
rtl/kwq_back.sv
rtl/keyed_wait_queue_wakeup.sv
verif/keyed_wait_queue_wakeup_test.sv
